/* hw/rtl/dfs_cycle_through_start_vertex_macros.svh */
// Assertion macros used by the port-level checker of the cycle search block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DFS_CYCLE_THROUGH_START_VERTEX_MACROS_SVH
`define DFS_CYCLE_THROUGH_START_VERTEX_MACROS_SVH

// Same-cycle implication, held off during reset.
`define DFSCY_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define DFSCY_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dfscy_pkg.sv */
// Shared types, constants and helpers of the cycle search block.
// No dependencies.
`timescale 1ns / 1ps

package dfscy_pkg;

    localparam int MAX_VERTICES_DEF = 63;
    localparam logic [5:0] START_VERTEX = 6'd1;

    // Controller states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_EDGE_B   = 9'b000000010,
        ST_ADJ_RD   = 9'b000000100,
        ST_MASK     = 9'b000001000,
        ST_PICK     = 9'b000010000,
        ST_POP_LD   = 9'b000100000,
        ST_EMIT_RD  = 9'b001000000,
        ST_EMIT_PUT = 9'b010000000,
        ST_NF_PUT   = 9'b100000000
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic edge_a;
        logic edge_b;
        logic run_init;
        logic adj_rd;
        logic mask;
        logic pick;
        logic pop_rd;
        logic pop_ld;
        logic emit_init;
        logic emit_rd;
        logic emit_put;
        logic nf_put;
        logic clear;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic none;
        logic root;
        logic close;
        logic out_free;
        logic emit_last;
    } sts_t;

    // Find lowest set bit of a byte: {any, index}
    function automatic logic [3:0] ffs8(input logic [7:0] v);
        logic [3:0] r;
        r = 4'b0000;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = {1'b1, 3'(i)};
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/dfs_cycle_through_start_vertex.sv */
// Top level of the cycle search block: controller plus datapath.
// Depends on dfscy_pkg, dfscy_ctrl and dfscy_dp.
`timescale 1ns / 1ps

// Searches an undirected graph for a cycle through vertex 1. An edge
// transaction (kind 0) writes its two adjacency rows one after the other; ids
// of 0 or above MAX_VERTICES are dropped. A run transaction (kind 1) does a
// depth-first search from vertex 1, lowest neighbor first. Each neighbor scan
// is an adjacency row read, a mask and a lowest-bit pick, and each backtrack
// adds a stack entry load. Scans are bounded by twice the edge count plus the
// vertex count. The cycle then leaves as 1, the tree path, 1, each result
// after its own stack memory read and held back while the output side
// stalls; with no cycle a single result with found = 0 and last = 1 is sent.
// The graph is cleared at the end of every run; input stays stalled until
// the last result is in the output register.
module dfs_cycle_through_start_vertex
#(
    parameter int MAX_VERTICES = dfscy_pkg::MAX_VERTICES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       kind,
    input  logic [5:0] end_a,
    input  logic [5:0] end_b,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic       found,
    output logic [5:0] vertex,
    output logic       last
);

    dfscy_pkg::cmd_t cmd;
    dfscy_pkg::sts_t sts;

    dfscy_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .kind      (kind),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dfscy_dp
    #(
        .MAX_VERTICES (MAX_VERTICES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .end_a     (end_a),
        .end_b     (end_b),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .found     (found),
        .vertex    (vertex),
        .last      (last)
    );

endmodule

/* hw/rtl/dfscy_ctrl.sv */
// Controller state machine of the cycle search block.
// Depends on dfscy_pkg; drives commands into dfscy_dp.
`timescale 1ns / 1ps

module dfscy_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              kind,
    output logic              req_stall,
    input  dfscy_pkg::sts_t   sts,
    output dfscy_pkg::cmd_t   cmd
);

    dfscy_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfscy_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != dfscy_pkg::ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            dfscy_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (kind)
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = dfscy_pkg::ST_ADJ_RD;
                    end
                    else
                    begin
                        cmd.edge_a = 1'b1;
                        state_next = dfscy_pkg::ST_EDGE_B;
                    end
                end
            end
            dfscy_pkg::ST_EDGE_B:
            begin
                cmd.edge_b = 1'b1;
                state_next = dfscy_pkg::ST_IDLE;
            end
            dfscy_pkg::ST_ADJ_RD:
            begin
                cmd.adj_rd = 1'b1;
                state_next = dfscy_pkg::ST_MASK;
            end
            dfscy_pkg::ST_MASK:
            begin
                cmd.mask   = 1'b1;
                state_next = dfscy_pkg::ST_PICK;
            end
            dfscy_pkg::ST_PICK:
            begin
                cmd.pick = 1'b1;
                if (sts.none)
                begin
                    if (sts.root)
                    begin
                        state_next = dfscy_pkg::ST_NF_PUT;
                    end
                    else
                    begin
                        cmd.pop_rd = 1'b1;
                        state_next = dfscy_pkg::ST_POP_LD;
                    end
                end
                else if (sts.close)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = dfscy_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = dfscy_pkg::ST_ADJ_RD;
                end
            end
            dfscy_pkg::ST_POP_LD:
            begin
                cmd.pop_ld = 1'b1;
                state_next = dfscy_pkg::ST_ADJ_RD;
            end
            dfscy_pkg::ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = dfscy_pkg::ST_EMIT_PUT;
            end
            dfscy_pkg::ST_EMIT_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_put = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = dfscy_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = dfscy_pkg::ST_EMIT_RD;
                    end
                end
            end
            dfscy_pkg::ST_NF_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.nf_put = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = dfscy_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dfscy_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/dfscy_dp.sv */
// Datapath of the cycle search block: adjacency memory, stack memory,
// visited marks, neighbor scan and result register. Depends on dfscy_pkg.
`timescale 1ns / 1ps

module dfscy_dp
#(
    parameter int MAX_VERTICES = dfscy_pkg::MAX_VERTICES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [5:0]        end_a,
    input  logic [5:0]        end_b,
    input  dfscy_pkg::cmd_t   cmd,
    output dfscy_pkg::sts_t   sts,
    input  logic              rsp_stall,
    output logic              rsp_valid,
    output logic              found,
    output logic [5:0]        vertex,
    output logic              last
);

    localparam logic [63:0] VMASK  = ((64'd1 << (MAX_VERTICES + 1)) - 64'd1) & ~64'd1;
    localparam logic [5:0]  MAX_ID = 6'(MAX_VERTICES);

    // Storage
    logic [63:0] adj_mem [64];
    logic [11:0] stk_mem [64];
    logic [63:0] row_valid_reg;
    logic [63:0] adj_rdata_reg;
    logic        adj_rv_reg;
    logic [63:0] masked_reg;
    logic [11:0] stk_rdata_reg;
    logic [63:0] visited_reg;
    logic [5:0]  top_v_reg;
    logic [5:0]  top_last_reg;
    logic [5:0]  top_idx_reg;
    logic [6:0]  emit_k_reg;
    logic [5:0]  a_reg, b_reg;
    logic        ok_reg;
    logic        out_valid_reg;
    logic        found_reg;
    logic [5:0]  vertex_reg;
    logic        last_reg;

    logic        a_ok;
    logic [7:0]  grp_any;
    logic [3:0]  gsel, bsel;
    logic [7:0]  grp_bits;
    logic [5:0]  w;
    logic        none, close, push;
    logic [6:0]  idx7;
    logic        last_hit;
    logic [5:0]  emit_v;
    logic [63:0] above;

    assign a_ok = (end_a != 6'd0) && (end_a <= MAX_ID) && (end_b != 6'd0) && (end_b <= MAX_ID);

    // Edge latch for the second row write
    always_ff @(posedge clk)
    begin
        if (cmd.edge_a)
        begin
            a_reg <= end_a;
            b_reg <= end_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.edge_a)
        begin
            ok_reg <= a_ok;
        end
    end

    // Adjacency rows: bit write, whole row on first write since clear
    always_ff @(posedge clk)
    begin
        if (cmd.edge_a && a_ok)
        begin
            if (row_valid_reg[end_a])
            begin
                adj_mem[end_a][end_b] <= 1'b1;
            end
            else
            begin
                adj_mem[end_a] <= 64'd1 << end_b;
            end
        end
        else if (cmd.edge_b && ok_reg)
        begin
            if (row_valid_reg[b_reg])
            begin
                adj_mem[b_reg][a_reg] <= 1'b1;
            end
            else
            begin
                adj_mem[b_reg] <= 64'd1 << a_reg;
            end
        end
        if (cmd.adj_rd)
        begin
            adj_rdata_reg <= adj_mem[top_v_reg];
            adj_rv_reg    <= row_valid_reg[top_v_reg];
        end
    end

    // Row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.edge_a && a_ok)
        begin
            row_valid_reg[end_a] <= 1'b1;
        end
        else if (cmd.edge_b && ok_reg)
        begin
            row_valid_reg[b_reg] <= 1'b1;
        end
    end

    // Mask off scanned and out-of-range neighbors
    assign above = ~((64'd2 << top_last_reg) - 64'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.mask)
        begin
            masked_reg <= (adj_rv_reg ? adj_rdata_reg : 64'd0) & above & VMASK;
        end
    end

    // Lowest remaining neighbor: group select then bit select
    always_comb
    begin
        for (int g = 0; g < 8; g++)
        begin
            grp_any[g] = |masked_reg[g*8 +: 8];
        end
    end

    assign gsel     = dfscy_pkg::ffs8(grp_any);
    assign grp_bits = masked_reg[{gsel[2:0], 3'b000} +: 8];
    assign bsel     = dfscy_pkg::ffs8(grp_bits);
    assign w        = {gsel[2:0], bsel[2:0]};
    assign none     = !gsel[3];
    // Parent of the top is vertex 1 exactly when the top sits at index 1
    assign close    = !none && (w == dfscy_pkg::START_VERTEX) && (top_idx_reg != 6'd1);
    assign push     = cmd.pick && !none && !close && !visited_reg[w];

    // Stack memory: entries below the top, {vertex, last scanned}
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_mem[top_idx_reg] <= {top_v_reg, w};
        end
        if (cmd.pop_rd)
        begin
            stk_rdata_reg <= stk_mem[top_idx_reg - 6'd1];
        end
        else if (cmd.emit_rd)
        begin
            stk_rdata_reg <= stk_mem[emit_k_reg[5:0]];
        end
    end

    // Search state: top of stack, marks, emit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            top_v_reg    <= '0;
            top_last_reg <= '0;
            top_idx_reg  <= '0;
            emit_k_reg   <= '0;
        end
        else
        begin
            if (cmd.run_init)
            begin
                visited_reg  <= 64'd1 << dfscy_pkg::START_VERTEX;
                top_v_reg    <= dfscy_pkg::START_VERTEX;
                top_last_reg <= '0;
                top_idx_reg  <= '0;
            end
            else if (cmd.pick && !none)
            begin
                if (push)
                begin
                    visited_reg[w] <= 1'b1;
                    top_idx_reg    <= top_idx_reg + 6'd1;
                    top_v_reg      <= w;
                    top_last_reg   <= '0;
                end
                else
                begin
                    top_last_reg <= w;
                end
            end
            else if (cmd.pop_ld)
            begin
                top_v_reg    <= stk_rdata_reg[11:6];
                top_last_reg <= stk_rdata_reg[5:0];
                top_idx_reg  <= top_idx_reg - 6'd1;
            end
            else if (cmd.clear)
            begin
                visited_reg <= '0;
                top_idx_reg <= '0;
            end
            if (cmd.emit_init)
            begin
                emit_k_reg <= '0;
            end
            else if (cmd.emit_put)
            begin
                emit_k_reg <= emit_k_reg + 7'd1;
            end
        end
    end

    // Cycle order: 1, stack entries 1..top-1, top vertex, 1
    assign idx7     = {1'b0, top_idx_reg};
    assign last_hit = (emit_k_reg == idx7 + 7'd1);
    assign emit_v   = ((emit_k_reg == 7'd0) || last_hit) ? dfscy_pkg::START_VERTEX :
                      (emit_k_reg == idx7) ? top_v_reg : stk_rdata_reg[11:6];

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_put || cmd.nf_put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_put)
        begin
            found_reg  <= 1'b1;
            vertex_reg <= emit_v;
            last_reg   <= last_hit;
        end
        else if (cmd.nf_put)
        begin
            found_reg  <= 1'b0;
            vertex_reg <= 6'd0;
            last_reg   <= 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign found     = found_reg;
    assign vertex    = vertex_reg;
    assign last      = last_reg;

    assign sts.none      = none;
    assign sts.root      = (top_idx_reg == 6'd0);
    assign sts.close     = close;
    assign sts.out_free  = !out_valid_reg || !rsp_stall;
    assign sts.emit_last = last_hit;

endmodule

/* hw/rtl/dfscy_chk.sv */
// Port-level checker for the cycle search block, bound to the top level.
// Depends on dfs_cycle_through_start_vertex_macros.svh.
`timescale 1ns / 1ps
`include "dfs_cycle_through_start_vertex_macros.svh"

module dfscy_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       kind,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic       found,
    input logic [5:0] vertex,
    input logic       last
);

    // A stalled result stays offered
    `DFSCY_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

    // A run transaction always holds the input side for a while
    `DFSCY_ASSERT_NEXT(a_run_stalls, req_valid && !req_stall && kind, req_stall, "run did not stall input")

    // Not-found is a single closing result with vertex 0
    `DFSCY_ASSERT_NOW(a_nf_shape, rsp_valid && !found, last && (vertex == 6'd0), "bad not-found result")

    // A cycle closes on vertex 1
    `DFSCY_ASSERT_NOW(a_cycle_close, rsp_valid && found && last, vertex == 6'd1, "cycle not closed on 1")

endmodule

bind dfs_cycle_through_start_vertex dfscy_chk u_chk (.*);

/* test/dfscy_checker.sv */
// Transaction checker for the cycle search block: watches both channels,
// predicts the cycle results of each run and compares them field by field.
// Depends on nothing but the channel signals of the block.
`timescale 1ns / 1ps

module dfscy_checker
#(
    parameter int MAXV = 63
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  logic       kind,
    input  logic [5:0] end_a,
    input  logic [5:0] end_b,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  logic       found,
    input  logic [5:0] vertex,
    input  logic       last,
    output int         errors,
    output int         pending
);

    typedef struct packed {
        logic       found;
        logic [5:0] vertex;
        logic       last;
    } cycle_step_t;

    cycle_step_t  cycle_steps_q[$];
    logic [63:0]  graph_rows [64];
    logic [63:0]  seen;
    logic [5:0]   parent_of [64];
    logic [5:0]   stk_vert [64];
    logic [5:0]   stk_scan [64];

    assign pending = cycle_steps_q.size();

    // Depth-first search from vertex 1, then queue the cycle (or a not-found result) and clear the graph
    task automatic run_cycle_search();
        int          depth;
        int          top;
        int          n;
        int          closer;
        logic [5:0]  u;
        logic [5:0]  w;
        logic [5:0]  path [64];
        cycle_step_t step;
        seen = '0;
        foreach (parent_of[i]) parent_of[i] = '0;
        seen[1] = 1'b1;
        stk_vert[0] = 6'd1;
        stk_scan[0] = 6'd0;
        depth = 1;
        closer = 0;
        while (depth > 0 && closer == 0)
        begin
            top = depth - 1;
            u = stk_vert[top];
            w = '0;
            for (int c = int'(stk_scan[top]) + 1; c <= MAXV && c < 64; c++)
            begin
                if (graph_rows[u][c])
                begin
                    w = 6'(c);
                    break;
                end
            end
            if (w == 0)
            begin
                depth--;
            end
            else
            begin
                stk_scan[top] = w;
                if (w == 6'd1 && parent_of[u] != 6'd1)
                begin
                    closer = u;
                end
                else if (!seen[w])
                begin
                    parent_of[w] = u;
                    seen[w] = 1'b1;
                    if (depth < 64)
                    begin
                        stk_vert[depth] = w;
                        stk_scan[depth] = '0;
                        depth++;
                    end
                end
            end
        end
        if (closer == 0)
        begin
            step = '{found: 1'b0, vertex: 6'd0, last: 1'b1};
            cycle_steps_q = {cycle_steps_q, step};
        end
        else
        begin
            // walk the tree back from the closing vertex
            n = 0;
            u = 6'(closer);
            while (u != 6'd1 && u != 6'd0 && n < 62)
            begin
                path[n] = u;
                n++;
                u = parent_of[u];
            end
            step = '{found: 1'b1, vertex: 6'd1, last: 1'b0};
            cycle_steps_q = {cycle_steps_q, step};
            for (int i = n - 1; i >= 0; i--)
            begin
                step = '{found: 1'b1, vertex: path[i], last: 1'b0};
                cycle_steps_q = {cycle_steps_q, step};
            end
            step = '{found: 1'b1, vertex: 6'd1, last: 1'b1};
            cycle_steps_q = {cycle_steps_q, step};
        end
        foreach (graph_rows[i]) graph_rows[i] = '0;
    endtask

    // Request side: load edges or run the search
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (graph_rows[i]) graph_rows[i] = '0;
        end
        else if (req_valid && !req_stall)
        begin
            if (kind == 1'b0)
            begin
                if (end_a != 0 && end_b != 0 && end_a <= MAXV && end_b <= MAXV)
                begin
                    graph_rows[end_a][end_b] = 1'b1;
                    graph_rows[end_b][end_a] = 1'b1;
                end
            end
            else
            begin
                run_cycle_search();
            end
        end
    end

    // Response side: compare against the oldest expected step
    always @(posedge clk or negedge rst_n)
    begin
        cycle_step_t want;
        if (!rst_n)
        begin
            errors <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            if (cycle_steps_q.size() == 0)
            begin
                $error("unexpected result: found=%0d vertex=%0d last=%0d",
                       found, vertex, last);
                errors <= errors + 1;
            end
            else
            begin
                want = cycle_steps_q.pop_front();
                if (want.found !== found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    errors <= errors + 1;
                end
                if (want.vertex !== vertex)
                begin
                    $error("vertex: expected %0d, got %0d", want.vertex, vertex);
                    errors <= errors + 1;
                end
                if (want.last !== last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    errors <= errors + 1;
                end
            end
        end
    end

endmodule

/* test/testbench.sv */
// Top of the cycle search testbench: clock, reset, stimulus and verdict.
// Depends on dfs_cycle_through_start_vertex and dfscy_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int MAXV      = 63;
    localparam int NUM_ITEMS = 170;
    localparam int LIMIT     = 500000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    logic       kind;
    logic [5:0] end_a;
    logic [5:0] end_b;
    logic       rsp_valid;
    logic       rsp_stall;
    logic       found;
    logic [5:0] vertex;
    logic       last;
    int         errors;
    int         pending;
    int         idle_pct;
    int         stall_pct;
    int         sent;
    int         cycles;

    dfs_cycle_through_start_vertex #(.MAX_VERTICES(MAXV)) DUT (.*);

    dfscy_checker #(.MAXV(MAXV)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL dfs_cycle_through_start_vertex");
            $finish;
        end
    end

    // Output side back-pressure
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // One request transaction, with random idle cycles ahead of it
    task automatic send(input logic k, input logic [5:0] a, input logic [5:0] b);
        logic s;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        end_a     <= a;
        end_b     <= b;
        do
        begin
            @(negedge clk);
            s = req_stall;
            @(posedge clk);
        end
        while (s);
        sent++;
        // idle and stall pattern follows progress through the item budget
        case (sent * 4 / NUM_ITEMS)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 78; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 78; end
            default: begin idle_pct = 19; stall_pct = 19; end
        endcase
    endtask

    task automatic add_edge(input int a, input int b);
        send(1'b0, 6'(a), 6'(b));
    endtask

    task automatic run_search();
        send(1'b1, 6'($urandom_range(63)), 6'($urandom_range(63)));
    endtask

    initial
    begin
        int k;
        int ne;
        int r;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        kind      <= 1'b0;
        end_a     <= '0;
        end_b     <= '0;
        idle_pct  = 0;
        stall_pct = 0;
        sent      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty graph, self-loop on 1, bad ids, repeats, triangles
        run_search();
        add_edge(1, 1);
        run_search();
        add_edge(0, 2);
        add_edge(1, 0);
        add_edge(1, 2);
        add_edge(2, 1);
        run_search();
        add_edge(2, 2);
        add_edge(1, 2);
        add_edge(2, 3);
        run_search();
        add_edge(1, 2);
        add_edge(2, 3);
        add_edge(3, 1);
        add_edge(3, 3);
        run_search();
        add_edge(1, 63);
        add_edge(63, 62);
        add_edge(62, 1);
        add_edge(63, 63);
        run_search();

        // Hold off until the pipeline has drained
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        // Longest cycle: through every vertex
        for (int v = 1; v < MAXV; v++) add_edge(v, v + 1);
        add_edge(MAXV, 1);
        run_search();

        // Random graphs, mostly on a few low ids so cycles through 1 are common
        while (sent < NUM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                k = (r < 4) ? MAXV : $urandom_range(2, 8);
                ne = $urandom_range(0, 2 * k);
                for (int i = 0; i < ne; i++)
                begin
                    add_edge($urandom_range(1, k), $urandom_range(1, k));
                end
                run_search();
            end
            else if (r < 95)
            begin
                add_edge($urandom_range(63), $urandom_range(63));
            end
            else
            begin
                run_search();
            end
        end

        // Drain and settle
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS dfs_cycle_through_start_vertex");
        end
        else
        begin
            $display("FAIL dfs_cycle_through_start_vertex");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dfscy_pkg.sv
hw/rtl/dfscy_ctrl.sv
hw/rtl/dfscy_dp.sv
hw/rtl/dfs_cycle_through_start_vertex.sv
hw/rtl/dfscy_chk.sv
test/dfscy_checker.sv
test/testbench.sv
